@@ rtl/bpi_pkg.sv @@
// shared types, operation codes and counter arithmetic for the position index builder
`default_nettype none

package bpi_pkg;

    localparam int CNT_BITS = 17;

    typedef logic [CNT_BITS-1:0] t_cnt;
    typedef logic [2:0]          t_kind;

    localparam t_cnt CNT_MAX = '1;

    localparam t_kind KIND_COUNT  = 3'd0;
    localparam t_kind KIND_BUILD  = 3'd1;
    localparam t_kind KIND_PLACE  = 3'd2;
    localparam t_kind KIND_LOOKUP = 3'd3;
    localparam t_kind KIND_READ   = 3'd4;

    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_BITS] ? CNT_MAX : s[CNT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/bpi_ram.sv @@
// single write port, single read port synchronous ram with registered read data
`default_nettype none

module bpi_ram #(
    parameter int AW    = 8,
    parameter int DEPTH = 256,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/bucketed_position_index_build.sv @@
// counting sort seed index: bucket counter store, position store and sequencer
// count, place, slot read and unused kinds: one request at a time, through ST_EXEC to a registered result strobe
// range lookup: one request at a time through ST_LK2 and ST_EXEC, two reads of the single counter read port
// build: one counter per cycle through the counter ram
// reset: synchronous, then a clearing pass over all 2^BUCKET_BITS + 2 counters with busy high
// the result strobe lasts one cycle and cannot be held off
`default_nettype none

module bucketed_position_index_build #(
    parameter int BUCKET_BITS   = 16,
    parameter int SLOT_COUNT    = 65536,
    parameter int POSITION_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_kind,
    input  wire logic [15:0] i_bucket,
    input  wire logic [31:0] i_position,
    input  wire logic [15:0] i_slot,
    output logic             o_done,
    output logic [16:0]      o_range_start,
    output logic [16:0]      o_range_end,
    output logic [31:0]      o_stored_position,
    output logic [15:0]      o_slot_written,
    output logic             o_error
);

    localparam int NUM_CNT = (1 << BUCKET_BITS) + 2;
    localparam int CAW     = BUCKET_BITS + 1;
    localparam int SAW     = $clog2(SLOT_COUNT);
    localparam int TCW     = $clog2(SLOT_COUNT + 1);

    localparam logic [CAW-1:0] CNT_LAST = CAW'(NUM_CNT - 1);

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_LK2  = 3'd2;
    localparam logic [2:0] ST_EXEC = 3'd3;
    localparam logic [2:0] ST_BLD  = 3'd4;

    logic [2:0]               r_state;
    bpi_pkg::t_kind           r_kind;
    logic [CAW-1:0]           r_caddr;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_slot_ok;
    logic [TCW-1:0]           r_total;
    logic [TCW-1:0]           r_placed;
    logic [CAW-1:0]           r_ptr;
    logic                     r_issue;
    logic                     r_pend;
    logic [CAW-1:0]           r_paddr;
    bpi_pkg::t_cnt            r_acc;
    bpi_pkg::t_cnt            r_lo;

    logic                     r_done;
    logic [16:0]              r_rs;
    logic [16:0]              r_re;
    logic [31:0]              r_sp;
    logic [15:0]              r_swr;
    logic                     r_err;

    logic [BUCKET_BITS-1:0]   bidx;
    logic [CAW-1:0]           bext;
    logic [CAW-1:0]           cnt_raddr;
    logic                     cnt_we;
    logic [CAW-1:0]           cnt_waddr;
    bpi_pkg::t_cnt            cnt_wdata;
    bpi_pkg::t_cnt            cnt_rdata;
    logic                     pos_we;
    logic [SAW-1:0]           pos_waddr;
    logic [SAW-1:0]           pos_raddr;
    logic [POSITION_BITS-1:0] pos_rdata;
    logic                     count_ok;
    logic                     place_ok;
    bpi_pkg::t_cnt            bsum;
    bpi_pkg::t_cnt            cnt_inc;

    assign bidx     = BUCKET_BITS'(i_bucket);
    assign bext     = CAW'(bidx);
    assign count_ok = r_total < TCW'(SLOT_COUNT);
    // slot held at bucket+1 must be inside the store and the counted total not reached
    assign place_ok = (r_placed < r_total) && (32'(cnt_rdata) < 32'(SLOT_COUNT));
    assign bsum     = bpi_pkg::sat_add(cnt_rdata, r_acc);
    assign cnt_inc  = bpi_pkg::sat_add(cnt_rdata, bpi_pkg::t_cnt'(1));
    assign pos_raddr = SAW'(i_slot);
    assign pos_waddr = SAW'(cnt_rdata);
    assign pos_we    = (r_state == ST_EXEC) && (r_kind == bpi_pkg::KIND_PLACE) && place_ok;

    always_comb begin
        priority if (r_state == ST_LK2) begin
            cnt_raddr = r_caddr + CAW'(1);
        end else if (r_state == ST_BLD) begin
            cnt_raddr = r_ptr;
        end else if (i_kind == bpi_pkg::KIND_COUNT) begin
            cnt_raddr = bext + CAW'(2);
        end else if (i_kind == bpi_pkg::KIND_PLACE) begin
            cnt_raddr = bext + CAW'(1);
        end else begin
            cnt_raddr = bext;
        end
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_caddr;
        cnt_wdata = cnt_inc;
        unique case (r_state)
            ST_CLR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_ptr;
                cnt_wdata = '0;
            end
            ST_EXEC: begin
                cnt_we = ((r_kind == bpi_pkg::KIND_COUNT) && count_ok) ||
                         ((r_kind == bpi_pkg::KIND_PLACE) && place_ok);
            end
            ST_BLD: begin
                // counter 0 only seeds the running sum
                cnt_we    = r_pend && (r_paddr != '0);
                cnt_waddr = r_paddr;
                cnt_wdata = bsum;
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    bpi_ram #(
        .AW    (CAW),
        .DEPTH (NUM_CNT),
        .DW    (bpi_pkg::CNT_BITS)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    bpi_ram #(
        .AW    (SAW),
        .DEPTH (SLOT_COUNT),
        .DW    (POSITION_BITS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (r_pos),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_ptr    <= '0;
            r_total  <= '0;
            r_placed <= '0;
            r_issue  <= 1'b0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_CLR: begin
                    r_ptr <= r_ptr + CAW'(1);
                    if (r_ptr == CNT_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_start) begin
                        r_kind    <= i_kind;
                        r_caddr   <= cnt_raddr;
                        r_pos     <= POSITION_BITS'(i_position);
                        r_slot_ok <= 32'(i_slot) < 32'(SLOT_COUNT);
                        if (i_kind == bpi_pkg::KIND_BUILD) begin
                            r_state <= ST_BLD;
                            r_ptr   <= '0;
                            r_issue <= 1'b1;
                            r_pend  <= 1'b0;
                        end else if (i_kind == bpi_pkg::KIND_LOOKUP) begin
                            r_state <= ST_LK2;
                        end else begin
                            r_state <= ST_EXEC;
                        end
                    end
                end
                ST_LK2: begin
                    r_lo    <= cnt_rdata;
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    r_done  <= 1'b1;
                    r_rs    <= '0;
                    r_re    <= '0;
                    r_sp    <= '0;
                    r_swr   <= '0;
                    r_err   <= 1'b0;
                    r_state <= ST_IDLE;
                    unique case (r_kind)
                        bpi_pkg::KIND_COUNT: begin
                            if (count_ok) begin
                                r_total <= r_total + TCW'(1);
                            end else begin
                                r_err <= 1'b1;
                            end
                        end
                        bpi_pkg::KIND_PLACE: begin
                            if (place_ok) begin
                                r_placed <= r_placed + TCW'(1);
                                r_swr    <= 16'(cnt_rdata);
                            end else begin
                                r_err <= 1'b1;
                            end
                        end
                        bpi_pkg::KIND_LOOKUP: begin
                            r_rs <= r_lo;
                            r_re <= cnt_rdata;
                        end
                        bpi_pkg::KIND_READ: begin
                            r_sp <= r_slot_ok ? 32'(pos_rdata) : 32'd0;
                        end
                        default: begin
                            r_err <= 1'b0;
                        end
                    endcase
                end
                ST_BLD: begin
                    // read of counter i overlaps the write of counter i-1
                    r_pend  <= r_issue;
                    r_paddr <= r_ptr;
                    if (r_issue) begin
                        if (r_ptr == CNT_LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_ptr <= r_ptr + CAW'(1);
                        end
                    end
                    if (r_pend) begin
                        r_acc <= (r_paddr == '0) ? cnt_rdata : bsum;
                    end
                    if (!r_issue && r_pend) begin
                        r_done  <= 1'b1;
                        r_rs    <= '0;
                        r_re    <= '0;
                        r_sp    <= '0;
                        r_swr   <= '0;
                        r_err   <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy            = (r_state != ST_IDLE);
    assign o_done            = r_done;
    assign o_range_start     = r_rs;
    assign o_range_end       = r_re;
    assign o_stored_position = r_sp;
    assign o_slot_written    = r_swr;
    assign o_error           = r_err;

endmodule

`default_nettype wire

@@ rtl/bpi_check.sv @@
// port level checks for the position index builder and their bind
`default_nettype none

module bpi_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_start,
    input wire logic        o_busy,
    input wire logic [2:0]  i_kind,
    input wire logic        o_done,
    input wire logic [16:0] o_range_start,
    input wire logic [16:0] o_range_end,
    input wire logic [31:0] o_stored_position,
    input wire logic [15:0] o_slot_written,
    input wire logic        o_error
);

    logic accept;
    logic simple_kind;

    assign accept      = i_start && !o_busy;
    assign simple_kind = (i_kind != bpi_pkg::KIND_BUILD) && (i_kind != bpi_pkg::KIND_LOOKUP);

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while a request is still in work");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy)
        else $error("request accepted but block not busy afterwards");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_error) |-> (o_range_start == '0) && (o_range_end == '0) &&
            (o_stored_position == '0) && (o_slot_written == '0))
        else $error("refused request carries result data");

    a_simple_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && simple_kind) |=> ##1 o_done)
        else $error("single access request did not finish in two cycles");

    a_lookup_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == bpi_pkg::KIND_LOOKUP)) |=> ##2 o_done)
        else $error("range lookup did not finish in three cycles");

endmodule

bind bucketed_position_index_build bpi_check u_bpi_check (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_start           (i_start),
    .o_busy            (o_busy),
    .i_kind            (i_kind),
    .o_done            (o_done),
    .o_range_start     (o_range_start),
    .o_range_end       (o_range_end),
    .o_stored_position (o_stored_position),
    .o_slot_written    (o_slot_written),
    .o_error           (o_error)
);

`default_nettype wire

@@ bench/tb_bucketed_position_index_build.sv @@
// testbench for the position index builder: queued requests, in-line index prediction, result checks
module tb_bucketed_position_index_build;

    localparam int SLOT_COUNT  = 65536;
    localparam int NUM_CTR     = 65538;
    localparam int STALL_LIMIT = 300000;

    localparam bpi_pkg::t_kind KIND_SPARE_FIRST = bpi_pkg::KIND_READ + 3'd1;
    localparam bpi_pkg::t_kind KIND_SPARE_LAST  = '1;

    typedef struct {
        bpi_pkg::t_kind kind;
        logic [15:0]    bucket;
        logic [31:0]    position;
        logic [15:0]    slot;
    } t_index_request;

    typedef struct packed {
        logic [16:0] range_start;
        logic [16:0] range_end;
        logic [31:0] stored_position;
        logic [15:0] slot_written;
        logic        error;
    } t_index_reply;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_start    = 1'b0;
    logic [2:0]  i_kind     = '0;
    logic [15:0] i_bucket   = '0;
    logic [31:0] i_position = '0;
    logic [15:0] i_slot     = '0;
    logic        o_busy;
    logic        o_done;
    logic [16:0] o_range_start;
    logic [16:0] o_range_end;
    logic [31:0] o_stored_position;
    logic [15:0] o_slot_written;
    logic        o_error;

    // predicted index state
    bpi_pkg::t_cnt slot_base   [0:NUM_CTR-1];
    logic [31:0]   pos_store   [0:SLOT_COUNT-1];
    bit            slot_filled [0:SLOT_COUNT-1];
    logic [15:0]   filled_slots [$];
    int            tally_total  = 0;
    int            placed_total = 0;

    t_index_request request_backlog [$];
    t_index_reply   pending_replies [$];
    t_index_request next_req;
    t_index_reply   want;

    int idle_style      = 1;
    int idle_left       = 0;
    int gap;
    int quiet_cycles    = 0;
    int mismatches      = 0;
    int results_checked = 0;
    int refusals        = 0;
    int kind_hits [0:7] = '{default: 0};

    bucketed_position_index_build uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_kind            (i_kind),
        .i_bucket          (i_bucket),
        .i_position        (i_position),
        .i_slot            (i_slot),
        .o_done            (o_done),
        .o_range_start     (o_range_start),
        .o_range_end       (o_range_end),
        .o_stored_position (o_stored_position),
        .o_slot_written    (o_slot_written),
        .o_error           (o_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        foreach (slot_base[n]) slot_base[n] = '0;
    end

    function automatic bpi_pkg::t_cnt capped_add(input bpi_pkg::t_cnt a,
                                                 input bpi_pkg::t_cnt inc);
        if (int'(a) + int'(inc) > int'(bpi_pkg::CNT_MAX)) return bpi_pkg::CNT_MAX;
        return a + inc;
    endfunction

    function automatic t_index_reply index_outcome(input bpi_pkg::t_kind kind,
                                                   input logic [15:0] bucket,
                                                   input logic [31:0] position,
                                                   input logic [15:0] slot);
        t_index_reply r;
        int b;
        int i;
        bpi_pkg::t_cnt at;
        r = '0;
        b = bucket;
        kind_hits[kind]++;
        case (kind)
            bpi_pkg::KIND_COUNT: begin
                if (tally_total >= SLOT_COUNT) begin
                    r.error = 1'b1;
                end else begin
                    slot_base[b + 2] = capped_add(slot_base[b + 2], bpi_pkg::t_cnt'(1));
                    tally_total++;
                end
            end
            bpi_pkg::KIND_BUILD: begin
                for (i = 1; i < NUM_CTR; i++)
                    slot_base[i] = capped_add(slot_base[i], slot_base[i - 1]);
            end
            bpi_pkg::KIND_PLACE: begin
                at = slot_base[b + 1];
                if (placed_total >= tally_total || at >= SLOT_COUNT) begin
                    r.error = 1'b1;
                end else begin
                    pos_store[at[15:0]] = position;
                    if (!slot_filled[at[15:0]]) begin
                        slot_filled[at[15:0]] = 1'b1;
                        filled_slots.insert(filled_slots.size(), at[15:0]);
                    end
                    slot_base[b + 1] = capped_add(at, bpi_pkg::t_cnt'(1));
                    placed_total++;
                    r.slot_written = at[15:0];
                end
            end
            bpi_pkg::KIND_LOOKUP: begin
                r.range_start = slot_base[b];
                r.range_end   = slot_base[b + 1];
            end
            bpi_pkg::KIND_READ: begin
                r.stored_position = pos_store[slot];
            end
            default: ;
        endcase
        if (r.error) refusals++;
        return r;
    endfunction

    function automatic void queue_request(input bpi_pkg::t_kind kind, input logic [15:0] bucket,
                                          input logic [31:0] position, input logic [15:0] slot);
        t_index_request q;
        q.kind     = kind;
        q.bucket   = bucket;
        q.position = position;
        q.slot     = slot;
        request_backlog.insert(request_backlog.size(), q);
    endfunction

    function automatic logic [15:0] filled_slot();
        return filled_slots[$urandom_range(0, filled_slots.size() - 1)];
    endfunction

    // lookups, reads of filled slots and unused kinds: none of them touch the index
    function automatic void queue_noise();
        case ($urandom_range(0, 2))
            0: queue_request(bpi_pkg::KIND_LOOKUP, 16'($urandom), $urandom, 16'($urandom));
            1: queue_request(bpi_pkg::KIND_READ, 16'($urandom), $urandom, filled_slot());
            default: queue_request(bpi_pkg::t_kind'(KIND_SPARE_FIRST + $urandom_range(0, 2)),
                                   16'($urandom), $urandom, 16'($urandom));
        endcase
    endfunction

    function automatic int draw_gap();
        int r;
        if (idle_style == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic drain_requests();
        while (request_backlog.size() != 0 || i_start || pending_replies.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start   <= 1'b0;
            idle_left <= 0;
        end else if (!i_start || !o_busy) begin
            gap = idle_left;
            if (i_start) gap = draw_gap();
            if (gap > 0 || request_backlog.size() == 0) begin
                i_start   <= 1'b0;
                idle_left <= (gap > 0) ? gap - 1 : 0;
            end else begin
                next_req   = request_backlog.pop_front();
                i_kind     <= next_req.kind;
                i_bucket   <= next_req.bucket;
                i_position <= next_req.position;
                i_slot     <= next_req.slot;
                i_start    <= 1'b1;
            end
        end
    end

    // result monitor: check the strobe first, then predict a request taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_replies.size() == 0) begin
                    flag_mismatch("result strobe with no request outstanding");
                end else begin
                    want = pending_replies.pop_front();
                    results_checked++;
                    if (o_range_start !== want.range_start)
                        flag_mismatch($sformatf("range_start %0h, expected %0h",
                                                o_range_start, want.range_start));
                    if (o_range_end !== want.range_end)
                        flag_mismatch($sformatf("range_end %0h, expected %0h",
                                                o_range_end, want.range_end));
                    if (o_stored_position !== want.stored_position)
                        flag_mismatch($sformatf("stored_position %0h, expected %0h",
                                                o_stored_position, want.stored_position));
                    if (o_slot_written !== want.slot_written)
                        flag_mismatch($sformatf("slot_written %0h, expected %0h",
                                                o_slot_written, want.slot_written));
                    if (o_error !== want.error)
                        flag_mismatch($sformatf("error %b, expected %b", o_error, want.error));
                end
            end
            if (i_start && !o_busy)
                pending_replies.insert(pending_replies.size(),
                                       index_outcome(i_kind, i_bucket, i_position, i_slot));
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request or result for %0d cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [15:0] hot [0:11];
        logic [15:0] tallied [$];
        bpi_pkg::t_kind kind;
        int n;
        int j;
        int k;
        int b;
        int tries;
        int spare_hits;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // opening: place with nothing counted, empty lookups, unused kinds
        queue_request(bpi_pkg::KIND_PLACE, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF);
        queue_request(bpi_pkg::KIND_LOOKUP, 16'h0000, '0, '0);
        queue_request(bpi_pkg::KIND_LOOKUP, 16'hFFFF, '0, '0);
        for (k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
            queue_request(bpi_pkg::t_kind'(k), 16'hFFFF, 32'hFFFF_FFFF,
                          k[0] ? 16'hFFFF : 16'h0000);
        // top bucket only, so the later episode starts from clean running starts
        repeat (4) queue_request(bpi_pkg::KIND_COUNT, 16'hFFFF, $urandom, 16'($urandom));
        queue_request(bpi_pkg::KIND_BUILD, 16'($urandom), $urandom, 16'($urandom));
        queue_request(bpi_pkg::KIND_LOOKUP, 16'hFFFF, $urandom, 16'($urandom));
        queue_request(bpi_pkg::KIND_PLACE, 16'hFFFF, 32'h0000_0000, 16'($urandom));
        queue_request(bpi_pkg::KIND_PLACE, 16'hFFFF, 32'hFFFF_FFFF, 16'($urandom));
        queue_request(bpi_pkg::KIND_PLACE, 16'hFFFF, 32'h8000_0000, 16'($urandom));
        queue_request(bpi_pkg::KIND_PLACE, 16'hFFFF, 32'h7FFF_FFFF, 16'($urandom));
        // every counted position placed: both get refused
        queue_request(bpi_pkg::KIND_PLACE, 16'hFFFF, $urandom, 16'($urandom));
        queue_request(bpi_pkg::KIND_PLACE, 16'h0000, $urandom, 16'($urandom));
        queue_request(bpi_pkg::KIND_LOOKUP, 16'hFFFF, $urandom, 16'($urandom));
        queue_request(bpi_pkg::KIND_LOOKUP, 16'hFFFE, $urandom, 16'($urandom));
        for (k = 0; k < 4; k++)
            queue_request(bpi_pkg::KIND_READ, 16'($urandom), $urandom, 16'(k));
        drain_requests();

        // well-formed build: count, running starts, place each counted position once
        foreach (hot[h]) hot[h] = 16'($urandom);
        hot[0] = 16'h0000;
        hot[1] = 16'hFFFE;
        hot[2] = 16'hFFFF;
        for (n = 0; n < 450; n++) begin
            b = ($urandom_range(0, 9) < 6) ? hot[$urandom_range(0, 11)] : $urandom_range(0, 65535);
            tallied.insert(tallied.size(), b[15:0]);
            queue_request(bpi_pkg::KIND_COUNT, b[15:0], $urandom, 16'($urandom));
            if ($urandom_range(0, 5) == 0) queue_noise();
        end
        queue_request(bpi_pkg::KIND_BUILD, 16'($urandom), $urandom, 16'($urandom));
        for (n = tallied.size() - 1; n > 0; n--) begin
            j = $urandom_range(0, n);
            b = tallied[n];
            tallied[n] = tallied[j];
            tallied[j] = b[15:0];
        end
        foreach (tallied[t]) begin
            queue_request(bpi_pkg::KIND_PLACE, tallied[t], $urandom, 16'($urandom));
            if ($urandom_range(0, 5) == 0) queue_noise();
        end
        drain_requests();

        // back-to-back readback of the finished index
        idle_style = 0;
        repeat (150) begin
            if ($urandom_range(0, 1))
                queue_request(bpi_pkg::KIND_LOOKUP,
                              tallied[$urandom_range(0, tallied.size() - 1)],
                              $urandom, 16'($urandom));
            else
                queue_request(bpi_pkg::KIND_READ, 16'($urandom), $urandom, filled_slot());
        end
        drain_requests();
        idle_style = 1;

        // out of phase: more counts and a build over finished ranges
        for (n = 0; n < 150; n++) begin
            queue_request(bpi_pkg::KIND_COUNT, 16'($urandom), $urandom, 16'($urandom));
            if ($urandom_range(0, 3) == 0) queue_noise();
        end
        queue_request(bpi_pkg::KIND_BUILD, 16'($urandom), $urandom, 16'($urandom));
        drain_requests();
        // low buckets still point inside the store, high ones have run past it
        for (n = 0; n < 160; n++) begin
            b = $urandom_range(0, 65535);
            if ($urandom_range(0, 9) < 7)
                for (tries = 0; tries < 64 && slot_base[b + 1] >= SLOT_COUNT; tries++)
                    b = $urandom_range(0, 8191);
            queue_request(bpi_pkg::KIND_PLACE, b[15:0], $urandom, 16'($urandom));
            if ($urandom_range(0, 4) == 0) queue_noise();
        end
        drain_requests();
        // repeated build drives the running sums into saturation
        queue_request(bpi_pkg::KIND_BUILD, 16'($urandom), $urandom, 16'($urandom));
        repeat (60) begin
            kind = bpi_pkg::t_kind'($urandom_range(0, 7));
            if (kind == bpi_pkg::KIND_BUILD) kind = bpi_pkg::KIND_LOOKUP;
            queue_request(kind, 16'($urandom), $urandom,
                          (kind == bpi_pkg::KIND_READ) ? filled_slot() : 16'($urandom));
        end
        drain_requests();

        // closing back-to-back mix of places, lookups and reads
        idle_style = 0;
        repeat (8) queue_request(bpi_pkg::KIND_PLACE, 16'($urandom_range(0, 8191)), $urandom,
                                 16'($urandom));
        repeat (8) queue_request(bpi_pkg::KIND_LOOKUP, 16'($urandom), $urandom, 16'($urandom));
        repeat (8) queue_request(bpi_pkg::KIND_READ, 16'($urandom), $urandom, filled_slot());
        drain_requests();

        repeat (16) @(negedge i_clk);
        spare_hits = 0;
        for (k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) spare_hits += kind_hits[k];
        $display("covered %0d count, %0d build, %0d place, %0d lookup, %0d read, %0d unused-kind",
                 kind_hits[bpi_pkg::KIND_COUNT], kind_hits[bpi_pkg::KIND_BUILD],
                 kind_hits[bpi_pkg::KIND_PLACE], kind_hits[bpi_pkg::KIND_LOOKUP],
                 kind_hits[bpi_pkg::KIND_READ], spare_hits);
        $display("%0d results checked, %0d refused requests, %0d position slots filled",
                 results_checked, refusals, filled_slots.size());
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
